// ===== hw/rtl/u8dv_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 stream decoder/validator.
`timescale 1ns / 1ps

package u8dv_pkg;

    // Width of the internal character counter (range 8..32).
    localparam int COUNT_BITS   = 16;
    localparam int CHAR_COUNT_W = 16;
    localparam int CODE_POINT_W = 21;
    localparam int SEQ_LEN_W    = 3;
    localparam int STATUS_W     = 3;
    localparam int PEND_W       = 2;
    localparam int PAYLOAD_W    = 7;

    localparam logic [7:0] MASK_TOP1   = 8'h80;
    localparam logic [7:0] MASK_TOP2   = 8'hC0;
    localparam logic [7:0] MASK_TOP3   = 8'hE0;
    localparam logic [7:0] MASK_TOP4   = 8'hF0;
    localparam logic [7:0] MASK_TOP5   = 8'hF8;
    localparam logic [7:0] PAT_CONT    = 8'h80;
    localparam logic [7:0] PAT_LEAD2   = 8'hC0;
    localparam logic [7:0] PAT_LEAD3   = 8'hE0;
    localparam logic [7:0] PAT_LEAD4   = 8'hF0;
    localparam logic [7:0] KEEP_CONT   = 8'h3F;
    localparam logic [7:0] KEEP_LEAD2  = 8'h1F;
    localparam logic [7:0] KEEP_LEAD3  = 8'h0F;
    localparam logic [7:0] KEEP_LEAD4  = 8'h07;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_CHAR     = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_END_OK   = 3'd3,
        ST_END_BAD  = 3'd4
    } status_t;

    // Byte classes found by the front end
    typedef enum logic [2:0] {
        K_NUL,
        K_ASCII,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_CONT,
        K_BAD
    } kind_t;

    // One classified word passed from front to back
    typedef struct packed {
        kind_t                 kind;
        logic [PAYLOAD_W-1:0]  bits;
    } cls_t;

    // Saturate the internal counter to the reported width
    function automatic logic [CHAR_COUNT_W-1:0] count_out(input logic [COUNT_BITS-1:0] cnt);
        localparam int WW = COUNT_BITS + CHAR_COUNT_W;
        logic [WW-1:0] ext;
        logic [WW-1:0] lim;
        ext = WW'(cnt);
        lim = WW'({CHAR_COUNT_W{1'b1}});
        if (ext > lim)
        begin
            return {CHAR_COUNT_W{1'b1}};
        end
        return ext[CHAR_COUNT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/u8dv_stream_if.sv =====
// Valid/ready channel interfaces for string bytes and decoded results.
`timescale 1ns / 1ps

interface u8dv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8dv_result_if;
    import u8dv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CODE_POINT_W-1:0] code_point;
    logic [SEQ_LEN_W-1:0]    seq_len;
    logic [STATUS_W-1:0]     status;
    logic [CHAR_COUNT_W-1:0] char_count;

    modport source (output valid, output code_point, output seq_len, output status,
                    output char_count, input ready);
    modport sink   (input valid, input code_point, input seq_len, input status,
                    input char_count, output ready);
endinterface

// ===== hw/rtl/u8dv_front.sv =====
// Front end: accept string bytes and classify them into byte kinds.
`timescale 1ns / 1ps

module u8dv_front
    import u8dv_pkg::*;
(
    u8dv_byte_if.sink  bytes,
    input  logic       q_full,
    output logic       q_push,
    output cls_t       q_data
);

    logic [7:0] b;

    assign b           = bytes.in_byte;
    assign bytes.ready = !q_full;
    assign q_push      = bytes.valid && !q_full;

    always_comb
    begin
        q_data.kind = K_BAD;
        q_data.bits = '0;
        priority if (b == 8'h00)
        begin
            q_data.kind = K_NUL;
        end
        else if ((b & MASK_TOP1) == 8'h00)
        begin
            q_data.kind = K_ASCII;
            q_data.bits = b[PAYLOAD_W-1:0];
        end
        else if ((b & MASK_TOP2) == PAT_CONT)
        begin
            q_data.kind = K_CONT;
            q_data.bits = PAYLOAD_W'(b & KEEP_CONT);
        end
        else if ((b & MASK_TOP3) == PAT_LEAD2)
        begin
            q_data.kind = K_LEAD2;
            q_data.bits = PAYLOAD_W'(b & KEEP_LEAD2);
        end
        else if ((b & MASK_TOP4) == PAT_LEAD3)
        begin
            q_data.kind = K_LEAD3;
            q_data.bits = PAYLOAD_W'(b & KEEP_LEAD3);
        end
        else if ((b & MASK_TOP5) == PAT_LEAD4)
        begin
            q_data.kind = K_LEAD4;
            q_data.bits = PAYLOAD_W'(b & KEEP_LEAD4);
        end
        else
        begin
            q_data.kind = K_BAD;
        end
    end

endmodule

// ===== hw/rtl/u8dv_fifo.sv =====
// Two-entry queue of classified words between front and back.
`timescale 1ns / 1ps

module u8dv_fifo
    import u8dv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cls_t head
);

    cls_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/u8dv_back.sv =====
// Back end: sequence state, code point assembly and the result register.
`timescale 1ns / 1ps

module u8dv_back
    import u8dv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  cls_t             q_head,
    output logic             q_pop,
    u8dv_result_if.source    chars
);

    logic [PEND_W-1:0]       pend_reg,    pend_next;
    logic [SEQ_LEN_W-1:0]    seqlen_reg,  seqlen_next;
    logic [CODE_POINT_W-1:0] partial_reg, partial_next;
    logic                    err_reg,     err_next;
    logic [COUNT_BITS-1:0]   cnt_reg,     cnt_next;

    logic                    out_valid_reg;
    logic [CODE_POINT_W-1:0] out_cp_reg;
    logic [SEQ_LEN_W-1:0]    out_len_reg;
    status_t                 out_status_reg;
    logic [CHAR_COUNT_W-1:0] out_count_reg;

    logic                    can_step;
    logic                    emit;
    logic [CODE_POINT_W-1:0] res_cp;
    logic [SEQ_LEN_W-1:0]    res_len;
    status_t                 res_status;
    logic [COUNT_BITS-1:0]   cnt_bump;
    logic [CODE_POINT_W-1:0] shifted;

    // The end result reports the count before it clears
    function automatic logic [COUNT_BITS-1:0] cnt_next_report(input kind_t k,
                                                              input logic [COUNT_BITS-1:0] cur,
                                                              input logic [COUNT_BITS-1:0] nxt);
        return (k == K_NUL) ? cur : nxt;
    endfunction

    // Take a word when the result register is free or being drained
    assign can_step = !out_valid_reg || chars.ready;
    assign q_pop    = q_not_empty && can_step;

    assign cnt_bump = (cnt_reg == {COUNT_BITS{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign shifted  = {partial_reg[CODE_POINT_W-7:0], q_head.bits[5:0]};

    always_comb
    begin
        pend_next    = pend_reg;
        seqlen_next  = seqlen_reg;
        partial_next = partial_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        res_cp       = '0;
        res_len      = '0;
        res_status   = ST_CHAR;

        if (q_head.kind == K_NUL)
        begin
            emit         = 1'b1;
            res_status   = (err_reg || pend_reg != '0) ? ST_END_BAD : ST_END_OK;
            pend_next    = '0;
            seqlen_next  = '0;
            partial_next = '0;
            err_next     = 1'b0;
            cnt_next     = '0;
        end
        else if (err_reg)
        begin
            // drop bytes until the terminator
        end
        else if (pend_reg == '0)
        begin
            unique case (q_head.kind)
                K_ASCII:
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_bump;
                    res_cp   = CODE_POINT_W'(q_head.bits);
                    res_len  = SEQ_LEN_W'(1);
                end
                K_LEAD2:
                begin
                    pend_next    = PEND_W'(1);
                    seqlen_next  = SEQ_LEN_W'(2);
                    partial_next = CODE_POINT_W'(q_head.bits);
                end
                K_LEAD3:
                begin
                    pend_next    = PEND_W'(2);
                    seqlen_next  = SEQ_LEN_W'(3);
                    partial_next = CODE_POINT_W'(q_head.bits);
                end
                K_LEAD4:
                begin
                    pend_next    = PEND_W'(3);
                    seqlen_next  = SEQ_LEN_W'(4);
                    partial_next = CODE_POINT_W'(q_head.bits);
                end
                default:
                begin
                    emit         = 1'b1;
                    res_status   = ST_BAD_LEAD;
                    err_next     = 1'b1;
                    pend_next    = '0;
                    seqlen_next  = '0;
                    partial_next = '0;
                end
            endcase
        end
        else if (q_head.kind != K_CONT)
        begin
            emit         = 1'b1;
            res_status   = ST_BAD_CONT;
            res_len      = seqlen_reg;
            err_next     = 1'b1;
            pend_next    = '0;
            seqlen_next  = '0;
            partial_next = '0;
        end
        else if (pend_reg == PEND_W'(1))
        begin
            emit         = 1'b1;
            res_cp       = shifted;
            res_len      = seqlen_reg;
            cnt_next     = cnt_bump;
            pend_next    = '0;
            seqlen_next  = '0;
            partial_next = '0;
        end
        else
        begin
            partial_next = shifted;
            pend_next    = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            seqlen_reg    <= '0;
            partial_reg   <= '0;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                pend_reg    <= pend_next;
                seqlen_reg  <= seqlen_next;
                partial_reg <= partial_next;
                err_reg     <= err_next;
                cnt_reg     <= cnt_next;
            end
            if (can_step)
            begin
                out_valid_reg <= q_pop && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_cp_reg     <= res_cp;
            out_len_reg    <= res_len;
            out_status_reg <= res_status;
            out_count_reg  <= count_out(cnt_next_report(q_head.kind, cnt_reg, cnt_next));
        end
    end

    assign chars.valid      = out_valid_reg;
    assign chars.code_point = out_cp_reg;
    assign chars.seq_len    = out_len_reg;
    assign chars.status     = out_status_reg;
    assign chars.char_count = out_count_reg;

endmodule

// ===== hw/rtl/utf8_stream_decoder_validator_unit.sv =====
// Top level of the UTF-8 stream decoder/validator.
//
//   channel  dir   payload                                      accepted when
//   bytes    in    in_byte[7:0]                                 valid && ready
//   chars    out   code_point[20:0] seq_len[2:0] status[2:0]    valid && ready
//                  char_count[15:0]
//
// One word per cycle sustained while chars.ready is high; an accepted byte is written into
// the queue, and the back end then steps its classified word from the queue into the
// result register, which presents the result.
// rst_n clears the queue, the sequence state and the result valid at once.
// A stalled result holds the back end; the two-entry queue absorbs the front
// until it fills, then bytes.ready drops.
`timescale 1ns / 1ps

module utf8_stream_decoder_validator_unit
    import u8dv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    u8dv_byte_if.sink     bytes,
    u8dv_result_if.source chars
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cls_t q_in;
    cls_t q_head;

    u8dv_front u_front (
        .bytes  (bytes),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    u8dv_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    u8dv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .chars       (chars)
    );

endmodule

// ===== verif/utf8_stream_decoder_validator_unit_tb.sv =====
// Testbench for the UTF-8 stream decoder/validator: directed and random strings checked against a predictor.
`timescale 1ns / 1ps

module utf8_stream_decoder_validator_unit_tb;
    import u8dv_pkg::*;

    localparam int  RAND_ITEMS   = 1750;
    localparam int  IDLE_PCT     = 24;
    localparam int  CALM_FROM    = 800;
    localparam int  CALM_TO      = 1200;
    localparam int  STALL_AT     = 300;
    localparam int  STALL_LEN    = 200;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  SHOW_MAX     = 10;

    typedef struct packed {
        logic [CODE_POINT_W-1:0] code_point;
        logic [SEQ_LEN_W-1:0]    seq_len;
        status_t                 status;
        logic [CHAR_COUNT_W-1:0] char_count;
    } char_res_t;

    logic clk;
    logic rst_n;

    u8dv_byte_if   bytes_ch ();
    u8dv_result_if chars_ch ();

    utf8_stream_decoder_validator_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_ch),
        .chars (chars_ch)
    );

    logic [7:0] tx_bytes [$];
    char_res_t  expected_chars [$];

    // Predictor state
    logic [PEND_W-1:0]       pend_cnt   = '0;
    logic [2:0]              open_len   = '0;
    logic [CODE_POINT_W-1:0] cp_acc     = '0;
    logic                    err_flag   = 1'b0;
    logic [COUNT_BITS-1:0]   char_tally = '0;

    int        mismatches   = 0;
    int        n_bytes_in   = 0;
    int        n_results    = 0;
    int        n_strings    = 0;
    int        n_errors     = 0;
    int        longest      = 0;
    int        rand_items   = 0;
    int        cyc          = 0;
    int        hold_left    = 0;
    logic      calm;
    char_res_t pred;
    char_res_t exp_c;

    function automatic logic [CHAR_COUNT_W-1:0] tally_report();
        longint unsigned c;
        c = longint'(char_tally);
        return (c > 64'hFFFF) ? {CHAR_COUNT_W{1'b1}} : c[CHAR_COUNT_W-1:0];
    endfunction

    function automatic void clear_open();
        pend_cnt = '0;
        open_len = '0;
        cp_acc   = '0;
    endfunction

    function automatic void bump_tally();
        if (char_tally != {COUNT_BITS{1'b1}})
        begin
            char_tally = char_tally + 1'b1;
        end
    endfunction

    // Advance the predicted decoder by one byte; return 1 when it yields a result.
    function automatic bit decode_byte(input logic [7:0] b, output char_res_t r);
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (b == 8'h00)
        begin
            r.status     = (err_flag || pend_cnt != 0) ? ST_END_BAD : ST_END_OK;
            r.char_count = tally_report();
            clear_open();
            err_flag   = 1'b0;
            char_tally = '0;
            return 1'b1;
        end
        if (err_flag)
        begin
            return 1'b0;
        end
        if (pend_cnt == 0)
        begin
            if ((b & MASK_TOP1) == 8'h00)
            begin
                bump_tally();
                r.code_point = CODE_POINT_W'(b[6:0]);
                r.seq_len    = 3'd1;
                r.status     = ST_CHAR;
                hit          = 1'b1;
            end
            else if ((b & MASK_TOP3) == PAT_LEAD2)
            begin
                pend_cnt = 2'd1;
                open_len = 3'd2;
                cp_acc   = CODE_POINT_W'(b & KEEP_LEAD2);
            end
            else if ((b & MASK_TOP4) == PAT_LEAD3)
            begin
                pend_cnt = 2'd2;
                open_len = 3'd3;
                cp_acc   = CODE_POINT_W'(b & KEEP_LEAD3);
            end
            else if ((b & MASK_TOP5) == PAT_LEAD4)
            begin
                pend_cnt = 2'd3;
                open_len = 3'd4;
                cp_acc   = CODE_POINT_W'(b & KEEP_LEAD4);
            end
            else
            begin
                err_flag = 1'b1;
                clear_open();
                r.status = ST_BAD_LEAD;
                hit      = 1'b1;
            end
        end
        else if ((b & MASK_TOP2) != PAT_CONT)
        begin
            // the offending byte is not reused as a lead
            r.seq_len = open_len;
            r.status  = ST_BAD_CONT;
            err_flag  = 1'b1;
            clear_open();
            hit       = 1'b1;
        end
        else
        begin
            cp_acc   = {cp_acc[CODE_POINT_W-7:0], b[5:0]};
            pend_cnt = pend_cnt - 1'b1;
            if (pend_cnt == 0)
            begin
                r.code_point = cp_acc;
                r.seq_len    = open_len;
                r.status     = ST_CHAR;
                clear_open();
                bump_tally();
                hit = 1'b1;
            end
        end
        if (hit)
        begin
            r.char_count = tally_report();
        end
        return hit;
    endfunction

    function automatic logic [7:0] cont_byte();
        return PAT_CONT | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return PAT_LEAD2 | 8'($urandom_range(0, 31));
            3:       return PAT_LEAD3 | 8'($urandom_range(0, 15));
            default: return PAT_LEAD4 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic push_char();
        int len;
        len = $urandom_range(1, 4);
        if (len == 1)
        begin
            tx_bytes.push_back(8'($urandom_range(1, 127)));
        end
        else
        begin
            tx_bytes.push_back(lead_byte(len));
            for (int k = 1; k < len; k++)
            begin
                tx_bytes.push_back(cont_byte());
            end
        end
        rand_items += len;
    endtask

    // One string of random characters, sometimes broken, then the terminator.
    task automatic push_string();
        int nchars;
        int flaw;
        int flaw_at;
        int len;
        int good;
        int junk;
        nchars  = $urandom_range(0, 12);
        flaw    = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
        flaw_at = $urandom_range(0, nchars);
        junk    = 0;
        for (int i = 0; i <= nchars; i++)
        begin
            if (flaw != 0 && i == flaw_at)
            begin
                len  = $urandom_range(2, 4);
                good = $urandom_range(0, len - 2);
                case (flaw)
                    1:
                    begin
                        tx_bytes.push_back($urandom_range(0, 1) ? cont_byte()
                                           : (8'hF8 | 8'($urandom_range(0, 7))));
                        rand_items++;
                        junk = $urandom_range(0, 4);
                    end
                    2:
                    begin
                        tx_bytes.push_back(lead_byte(len));
                        for (int k = 0; k < good; k++)
                        begin
                            tx_bytes.push_back(cont_byte());
                        end
                        tx_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(1, 127))
                                           : 8'($urandom_range(192, 255)));
                        rand_items += good + 2;
                        junk = $urandom_range(0, 4);
                    end
                    3:
                    begin
                        // end the string inside an open sequence
                        tx_bytes.push_back(lead_byte(len));
                        for (int k = 0; k < good; k++)
                        begin
                            tx_bytes.push_back(cont_byte());
                        end
                        rand_items += good + 1;
                    end
                    default:
                    begin
                        tx_bytes.push_back(8'($urandom_range(1, 255)));
                        rand_items++;
                        junk = $urandom_range(0, 4);
                    end
                endcase
                break;
            end
            if (i < nchars)
            begin
                push_char();
            end
        end
        for (int k = 0; k < junk; k++)
        begin
            tx_bytes.push_back(8'($urandom_range(1, 255)));
        end
        rand_items += junk;
        tx_bytes.push_back(8'h00);
        rand_items++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Cycle count, quiet window and the long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc       <= 0;
            hold_left <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (cyc == STALL_AT)
            begin
                hold_left <= STALL_LEN;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_ch.valid   <= 1'b0;
            bytes_ch.in_byte <= 8'h00;
        end
        else
        begin
            if (bytes_ch.valid && bytes_ch.ready)
            begin
                n_bytes_in++;
                if (decode_byte(bytes_ch.in_byte, pred))
                begin
                    expected_chars.push_back(pred);
                end
            end
            if (!bytes_ch.valid || bytes_ch.ready)
            begin
                if (tx_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    bytes_ch.valid   <= 1'b1;
                    bytes_ch.in_byte <= tx_bytes.pop_front();
                end
                else
                begin
                    bytes_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_ch.ready <= 1'b0;
        end
        else
        begin
            if (chars_ch.valid && chars_ch.ready)
            begin
                n_results++;
                if (chars_ch.status == ST_END_OK || chars_ch.status == ST_END_BAD)
                begin
                    n_strings++;
                    if (int'(chars_ch.char_count) > longest)
                    begin
                        longest = int'(chars_ch.char_count);
                    end
                end
                if (chars_ch.status == ST_BAD_LEAD || chars_ch.status == ST_BAD_CONT)
                begin
                    n_errors++;
                end
                if (expected_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                    begin
                        $display("%0t: unexpected result cp=%h len=%0d st=%0d cnt=%0d", $realtime,
                                 chars_ch.code_point, chars_ch.seq_len, chars_ch.status,
                                 chars_ch.char_count);
                    end
                end
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (chars_ch.code_point !== exp_c.code_point ||
                        chars_ch.seq_len !== exp_c.seq_len ||
                        chars_ch.status !== exp_c.status ||
                        chars_ch.char_count !== exp_c.char_count)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX)
                        begin
                            $display("%0t: result %0d exp cp=%h len=%0d st=%0d cnt=%0d", $realtime,
                                     n_results, exp_c.code_point, exp_c.seq_len, exp_c.status,
                                     exp_c.char_count);
                            $display("%0t: result %0d got cp=%h len=%0d st=%0d cnt=%0d", $realtime,
                                     n_results, chars_ch.code_point, chars_ch.seq_len,
                                     chars_ch.status, chars_ch.char_count);
                        end
                    end
                end
            end
            chars_ch.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        logic [7:0] directed [26] = '{
            8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
            8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00,
            8'h80, 8'hFF, 8'h00,
            8'hF8, 8'h00,
            8'hE2, 8'h41, 8'h41, 8'h00,
            8'hF0, 8'h90, 8'h00
        };
        rst_n = 1'b0;

        foreach (directed[i])
        begin
            tx_bytes.push_back(directed[i]);
        end
        while (rand_items < RAND_ITEMS)
        begin
            push_string();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || bytes_ch.valid)
        begin
            @(posedge clk);
        end
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes; checked %0d results over %0d strings, %0d with decode errors.",
                 n_bytes_in, n_results, n_strings, n_errors);
        $display("Longest string reported %0d characters; %0d mismatches.", longest, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout: %0d results still outstanding", expected_chars.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/u8dv_pkg.sv
hw/rtl/u8dv_stream_if.sv
hw/rtl/u8dv_front.sv
hw/rtl/u8dv_fifo.sv
hw/rtl/u8dv_back.sv
hw/rtl/utf8_stream_decoder_validator_unit.sv
verif/utf8_stream_decoder_validator_unit_tb.sv
